// File: src/tsm_pkg.sv
// tsm_pkg: shared widths, sideband types and selection tables for the
// triangle stiffness entry pipeline
// no dependencies; used by tsm_div and triangle_stiffness_entries_unit
package tsm_pkg;

    // vertex index width kept from the input, and port width of the indices
    localparam int INDEX_BITS = 24;
    localparam int IDX_W      = 24;
    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'((64'd1 << INDEX_BITS) - 64'd1);

    // entry counter over the nine beats of one triangle
    localparam int          CNT_W  = 4;
    localparam logic [CNT_W-1:0] LAST_K = CNT_W'(8);

    // datapath widths
    localparam int CRD_W  = 32;   // input coordinate
    localparam int AREA_W = 48;   // input area
    localparam int VAL_W  = 64;   // output value
    localparam int DIF_W  = 33;   // edge vector component
    localparam int GRD_W  = 34;   // gradient numerator
    localparam int MUL_W  = 66;   // edge product
    localparam int DET_W  = 67;   // signed determinant
    localparam int DMG_W  = 66;   // determinant magnitude
    localparam int PP_W   = 68;   // gradient product
    localparam int NUM_W  = 69;   // signed numerator
    localparam int NMG_W  = 68;   // numerator magnitude
    localparam int APP_W  = 58;   // numerator by area partial product
    localparam int PROD_W = 116;  // numerator by area
    localparam int DSQ_W  = 132;  // determinant squared
    localparam int REM_W  = 133;  // divisor and partial remainder
    localparam int DVD_W  = 166;  // dividend
    localparam int DIV_STEPS = 64;

    // vertex position codes
    typedef logic [1:0] vsel_t;
    localparam vsel_t VTX_A = 2'd0;
    localparam vsel_t VTX_B = 2'd1;
    localparam vsel_t VTX_C = 2'd2;

    // per-entry sideband that travels with the data
    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last_tri;
        logic             end_mesh;
        logic             degen;
        logic             neg;
        logic             zero;
        logic             ovf;
    } side_t;

    // gradient numerator pair of one vertex
    typedef struct packed {
        logic signed [GRD_W-1:0] p;
        logic signed [GRD_W-1:0] q;
    } grad_t;

    // row vertex of entry k: diagonals, then symmetric pairs
    function automatic vsel_t row_sel(input logic [CNT_W-1:0] k);
        vsel_t r;
        case (k)
            4'd0, 4'd3, 4'd8: r = VTX_A;
            4'd1, 4'd4, 4'd5: r = VTX_B;
            default:          r = VTX_C;
        endcase
        return r;
    endfunction

    // column vertex of entry k
    function automatic vsel_t col_sel(input logic [CNT_W-1:0] k);
        vsel_t r;
        case (k)
            4'd0, 4'd4, 4'd7: r = VTX_A;
            4'd1, 4'd3, 4'd6: r = VTX_B;
            default:          r = VTX_C;
        endcase
        return r;
    endfunction

    // first gradient of the product for entry k
    function automatic vsel_t gi_sel(input logic [CNT_W-1:0] k);
        vsel_t r;
        case (k)
            4'd0, 4'd3, 4'd4: r = VTX_A;
            4'd1, 4'd5, 4'd6: r = VTX_B;
            default:          r = VTX_C;
        endcase
        return r;
    endfunction

    // second gradient of the product for entry k
    function automatic vsel_t gj_sel(input logic [CNT_W-1:0] k);
        vsel_t r;
        case (k)
            4'd0, 4'd7, 4'd8: r = VTX_A;
            4'd1, 4'd3, 4'd4: r = VTX_B;
            default:          r = VTX_C;
        endcase
        return r;
    endfunction

endpackage

// File: src/tsm_div.sv
// tsm_div: pipelined restoring divider, one quotient bit per stage
// depends on tsm_pkg; instantiated by triangle_stiffness_entries_unit
module tsm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  tsm_pkg::side_t             in_side,
    input  logic [tsm_pkg::REM_W-1:0]  in_rem,
    input  logic [tsm_pkg::VAL_W-1:0]  in_lq,
    input  logic [tsm_pkg::REM_W-1:0]  in_div2,
    output logic                       out_valid,
    output tsm_pkg::side_t             out_side,
    output logic [tsm_pkg::VAL_W-1:0]  out_quo
);

    logic                       v_reg    [tsm_pkg::DIV_STEPS];
    tsm_pkg::side_t             side_reg [tsm_pkg::DIV_STEPS];
    logic [tsm_pkg::REM_W-1:0]  rem_reg  [tsm_pkg::DIV_STEPS];
    logic [tsm_pkg::VAL_W-1:0]  lq_reg   [tsm_pkg::DIV_STEPS];
    logic [tsm_pkg::REM_W-1:0]  div2_reg [tsm_pkg::DIV_STEPS];

    logic                       v_next    [tsm_pkg::DIV_STEPS];
    tsm_pkg::side_t             side_next [tsm_pkg::DIV_STEPS];
    logic [tsm_pkg::REM_W-1:0]  rem_next  [tsm_pkg::DIV_STEPS];
    logic [tsm_pkg::VAL_W-1:0]  lq_next   [tsm_pkg::DIV_STEPS];
    logic [tsm_pkg::REM_W-1:0]  div2_next [tsm_pkg::DIV_STEPS];

    // one compare and subtract per stage; dividend bits leave the top of
    // lq while quotient bits enter at the bottom
    always_comb
    begin
        logic                      src_v;
        tsm_pkg::side_t            src_side;
        logic [tsm_pkg::REM_W-1:0] src_rem;
        logic [tsm_pkg::VAL_W-1:0] src_lq;
        logic [tsm_pkg::REM_W-1:0] src_div2;
        logic [tsm_pkg::REM_W:0]   t;
        logic [tsm_pkg::REM_W:0]   d;
        logic                      ge;
        for (int s = 0; s < tsm_pkg::DIV_STEPS; s++)
        begin
            if (s == 0)
            begin
                src_v    = in_valid;
                src_side = in_side;
                src_rem  = in_rem;
                src_lq   = in_lq;
                src_div2 = in_div2;
            end
            else
            begin
                src_v    = v_reg[s-1];
                src_side = side_reg[s-1];
                src_rem  = rem_reg[s-1];
                src_lq   = lq_reg[s-1];
                src_div2 = div2_reg[s-1];
            end
            t  = {src_rem, src_lq[tsm_pkg::VAL_W-1]};
            d  = {1'b0, src_div2};
            ge = (t >= d);
            v_next[s]    = src_v;
            side_next[s] = src_side;
            rem_next[s]  = ge ? tsm_pkg::REM_W'(t - d) : t[tsm_pkg::REM_W-1:0];
            lq_next[s]   = {src_lq[tsm_pkg::VAL_W-2:0], ge};
            div2_next[s] = src_div2;
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < tsm_pkg::DIV_STEPS; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            for (int s = 0; s < tsm_pkg::DIV_STEPS; s++)
            begin
                v_reg[s] <= v_next[s];
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < tsm_pkg::DIV_STEPS; s++)
            begin
                side_reg[s] <= side_next[s];
                rem_reg[s]  <= rem_next[s];
                lq_reg[s]   <= lq_next[s];
                div2_reg[s] <= div2_next[s];
            end
        end
    end

    assign out_valid = v_reg[tsm_pkg::DIV_STEPS-1];
    assign out_side  = side_reg[tsm_pkg::DIV_STEPS-1];
    assign out_quo   = lq_reg[tsm_pkg::DIV_STEPS-1];

endmodule

// File: src/triangle_stiffness_entries_unit.sv
// triangle_stiffness_entries_unit: P1 triangle stiffness entries, nine beats
// out per triangle; depends on tsm_pkg and tsm_div
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall  vertex_a..c, ax..cy, tri_area, last_triangle
//  out      source     out_valid/out_stall  row_index, col_index, entry_value, flags
//
//  an input triangle is held while its nine entries are issued, one per cycle
//  unless out_stall holds the pipeline; the next triangle is taken in the
//  cycle its ninth entry issues. each entry runs through nine arithmetic
//  stages, the 64 stages of the divider and the output register before
//  out_valid. reset clears all valid bits. out_stall freezes the whole
//  pipeline while the output register holds a beat.
module triangle_stiffness_entries_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tsm_pkg::IDX_W-1:0]         vertex_a,
    input  logic [tsm_pkg::IDX_W-1:0]         vertex_b,
    input  logic [tsm_pkg::IDX_W-1:0]         vertex_c,
    input  logic signed [tsm_pkg::CRD_W-1:0]  ax,
    input  logic signed [tsm_pkg::CRD_W-1:0]  ay,
    input  logic signed [tsm_pkg::CRD_W-1:0]  bx,
    input  logic signed [tsm_pkg::CRD_W-1:0]  by_coord,
    input  logic signed [tsm_pkg::CRD_W-1:0]  cx,
    input  logic signed [tsm_pkg::CRD_W-1:0]  cy,
    input  logic [tsm_pkg::AREA_W-1:0]        tri_area,
    input  logic                              last_triangle,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tsm_pkg::IDX_W-1:0]         row_index,
    output logic [tsm_pkg::IDX_W-1:0]         col_index,
    output logic signed [tsm_pkg::VAL_W-1:0]  entry_value,
    output logic                              degenerate,
    output logic                              last_of_triangle,
    output logic                              end_of_mesh
);

    localparam logic [tsm_pkg::VAL_W-1:0] VAL_MAX = {1'b0, {(tsm_pkg::VAL_W-1){1'b1}}};
    localparam logic [tsm_pkg::VAL_W-1:0] VAL_MIN = {1'b1, {(tsm_pkg::VAL_W-1){1'b0}}};

    // gradient numerators of one vertex from the edge vectors
    function automatic tsm_pkg::grad_t grad(
        input tsm_pkg::vsel_t                   sel,
        input logic signed [tsm_pkg::DIF_W-1:0] dx1,
        input logic signed [tsm_pkg::DIF_W-1:0] dy1,
        input logic signed [tsm_pkg::DIF_W-1:0] dx2,
        input logic signed [tsm_pkg::DIF_W-1:0] dy2
    );
        tsm_pkg::grad_t g;
        case (sel)
            tsm_pkg::VTX_A:
            begin
                g.p = tsm_pkg::GRD_W'(dy1) - tsm_pkg::GRD_W'(dy2);
                g.q = tsm_pkg::GRD_W'(dx2) - tsm_pkg::GRD_W'(dx1);
            end
            tsm_pkg::VTX_B:
            begin
                g.p = tsm_pkg::GRD_W'(dy2);
                g.q = -tsm_pkg::GRD_W'(dx2);
            end
            default:
            begin
                g.p = -tsm_pkg::GRD_W'(dy1);
                g.q = tsm_pkg::GRD_W'(dx1);
            end
        endcase
        return g;
    endfunction

    function automatic logic [tsm_pkg::IDX_W-1:0] pick(
        input tsm_pkg::vsel_t              sel,
        input logic [tsm_pkg::IDX_W-1:0]   a,
        input logic [tsm_pkg::IDX_W-1:0]   b,
        input logic [tsm_pkg::IDX_W-1:0]   c
    );
        logic [tsm_pkg::IDX_W-1:0] r;
        case (sel)
            tsm_pkg::VTX_A: r = a;
            tsm_pkg::VTX_B: r = b;
            default:        r = c;
        endcase
        return r;
    endfunction

    logic adv;
    logic accept;
    logic fire;

    // held triangle
    logic                              itm_valid_reg;
    logic [tsm_pkg::CNT_W-1:0]         cnt_reg;
    logic [tsm_pkg::IDX_W-1:0]         va_reg, vb_reg, vc_reg;
    logic signed [tsm_pkg::CRD_W-1:0]  ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic [tsm_pkg::AREA_W-1:0]        area_reg;
    logic                              lastt_reg;

    // stage 1: edge vectors
    logic                              s1_v_reg;
    logic signed [tsm_pkg::DIF_W-1:0]  s1_dx1_reg, s1_dy1_reg, s1_dx2_reg, s1_dy2_reg;
    tsm_pkg::vsel_t                    s1_gi_reg, s1_gj_reg;
    logic [tsm_pkg::AREA_W-1:0]        s1_area_reg;
    tsm_pkg::side_t                    s1_side_reg, s1_side_next;

    // stage 2: gradients and edge products
    logic                              s2_v_reg;
    tsm_pkg::grad_t                    s2_gi_reg, s2_gj_reg;
    logic signed [tsm_pkg::MUL_W-1:0]  s2_m1_reg, s2_m2_reg;
    logic [tsm_pkg::AREA_W-1:0]        s2_area_reg;
    tsm_pkg::side_t                    s2_side_reg;

    // stage 3: gradient products and determinant
    logic                              s3_v_reg;
    logic signed [tsm_pkg::PP_W-1:0]   s3_pp_reg, s3_qq_reg;
    logic signed [tsm_pkg::DET_W-1:0]  s3_det_reg;
    logic [tsm_pkg::AREA_W-1:0]        s3_area_reg;
    tsm_pkg::side_t                    s3_side_reg;

    // stage 4: numerator and determinant magnitude
    logic                              s4_v_reg;
    logic signed [tsm_pkg::NUM_W-1:0]  s4_num_reg;
    logic [tsm_pkg::DMG_W-1:0]         s4_dmag_reg;
    logic [tsm_pkg::AREA_W-1:0]        s4_area_reg;
    tsm_pkg::side_t                    s4_side_reg, s4_side_next;

    // stage 5: numerator magnitude, determinant square partials
    logic                              s5_v_reg;
    logic [tsm_pkg::NMG_W-1:0]         s5_nmag_reg;
    logic [tsm_pkg::MUL_W-1:0]         s5_ll_reg, s5_lh_reg, s5_hh_reg;
    logic [tsm_pkg::AREA_W-1:0]        s5_area_reg;
    tsm_pkg::side_t                    s5_side_reg, s5_side_next;

    // stage 6: determinant square, numerator by area partials
    logic                              s6_v_reg;
    logic [tsm_pkg::DSQ_W-1:0]         s6_dsq_reg;
    logic [tsm_pkg::APP_W-1:0]         s6_a00_reg, s6_a01_reg, s6_a10_reg, s6_a11_reg;
    tsm_pkg::side_t                    s6_side_reg;

    // stage 7: numerator by area
    logic                              s7_v_reg;
    logic [tsm_pkg::PROD_W-1:0]        s7_prod_reg;
    logic [tsm_pkg::DSQ_W-1:0]         s7_dsq_reg;
    tsm_pkg::side_t                    s7_side_reg;

    // stage 8: rounded dividend and doubled divisor
    logic                              s8_v_reg;
    logic [tsm_pkg::DVD_W-1:0]         s8_dvd_reg;
    logic [tsm_pkg::REM_W-1:0]         s8_div2_reg;
    tsm_pkg::side_t                    s8_side_reg;

    // stage 9: divider entry with overflow check
    logic                              s9_v_reg;
    logic [tsm_pkg::REM_W-1:0]         s9_rem_reg, s9_rem_next;
    logic [tsm_pkg::VAL_W-1:0]         s9_lq_reg;
    logic [tsm_pkg::REM_W-1:0]         s9_div2_reg;
    tsm_pkg::side_t                    s9_side_reg, s9_side_next;

    // divider output
    logic                              dv_valid;
    tsm_pkg::side_t                    dv_side;
    logic [tsm_pkg::VAL_W-1:0]         dv_quo;

    // output register
    logic                              out_valid_reg;
    logic [tsm_pkg::IDX_W-1:0]         row_reg, col_reg;
    logic [tsm_pkg::VAL_W-1:0]         value_reg, value_next;
    logic                              degen_reg, lastt_out_reg, eom_reg;

    // whole pipeline moves unless a held output beat is stalled
    assign adv      = !(out_valid_reg && out_stall);
    assign fire     = itm_valid_reg && adv;
    assign in_stall = itm_valid_reg && !(fire && (cnt_reg == tsm_pkg::LAST_K));
    assign accept   = in_valid && !in_stall;

    // triangle holding register and entry counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            itm_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else if (accept)
        begin
            itm_valid_reg <= 1'b1;
            cnt_reg       <= '0;
        end
        else if (fire && (cnt_reg == tsm_pkg::LAST_K))
        begin
            itm_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else if (fire)
        begin
            cnt_reg <= cnt_reg + tsm_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            va_reg    <= vertex_a & tsm_pkg::IDX_MASK;
            vb_reg    <= vertex_b & tsm_pkg::IDX_MASK;
            vc_reg    <= vertex_c & tsm_pkg::IDX_MASK;
            ax_reg    <= ax;
            ay_reg    <= ay;
            bx_reg    <= bx;
            by_reg    <= by_coord;
            cx_reg    <= cx;
            cy_reg    <= cy;
            area_reg  <= tri_area;
            lastt_reg <= last_triangle;
        end
    end

    // sideband of the entry being issued
    always_comb
    begin
        s1_side_next          = '0;
        s1_side_next.row      = pick(tsm_pkg::row_sel(cnt_reg), va_reg, vb_reg, vc_reg);
        s1_side_next.col      = pick(tsm_pkg::col_sel(cnt_reg), va_reg, vb_reg, vc_reg);
        s1_side_next.last_tri = (cnt_reg == tsm_pkg::LAST_K);
        s1_side_next.end_mesh = (cnt_reg == tsm_pkg::LAST_K) && lastt_reg;
    end

    // sideband updates in later stages
    always_comb
    begin
        s4_side_next       = s3_side_reg;
        s4_side_next.degen = (s3_det_reg == '0);
        s5_side_next       = s4_side_reg;
        s5_side_next.neg   = s4_num_reg[tsm_pkg::NUM_W-1];
        s5_side_next.zero  = (s4_num_reg == '0);
        s9_rem_next        = tsm_pkg::REM_W'(s8_dvd_reg[tsm_pkg::DVD_W-1:tsm_pkg::VAL_W]);
        s9_side_next       = s8_side_reg;
        s9_side_next.ovf   = (s9_rem_next >= s8_div2_reg);
    end

    // valid bits of the arithmetic stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
            s7_v_reg <= 1'b0;
            s8_v_reg <= 1'b0;
            s9_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= itm_valid_reg;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
            s7_v_reg <= s6_v_reg;
            s8_v_reg <= s7_v_reg;
            s9_v_reg <= s8_v_reg;
        end
    end

    // arithmetic stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1
            s1_dx1_reg  <= tsm_pkg::DIF_W'(bx_reg) - tsm_pkg::DIF_W'(ax_reg);
            s1_dy1_reg  <= tsm_pkg::DIF_W'(by_reg) - tsm_pkg::DIF_W'(ay_reg);
            s1_dx2_reg  <= tsm_pkg::DIF_W'(cx_reg) - tsm_pkg::DIF_W'(ax_reg);
            s1_dy2_reg  <= tsm_pkg::DIF_W'(cy_reg) - tsm_pkg::DIF_W'(ay_reg);
            s1_gi_reg   <= tsm_pkg::gi_sel(cnt_reg);
            s1_gj_reg   <= tsm_pkg::gj_sel(cnt_reg);
            s1_area_reg <= area_reg;
            s1_side_reg <= s1_side_next;

            // stage 2
            s2_gi_reg   <= grad(s1_gi_reg, s1_dx1_reg, s1_dy1_reg, s1_dx2_reg, s1_dy2_reg);
            s2_gj_reg   <= grad(s1_gj_reg, s1_dx1_reg, s1_dy1_reg, s1_dx2_reg, s1_dy2_reg);
            s2_m1_reg   <= tsm_pkg::MUL_W'(s1_dy2_reg) * tsm_pkg::MUL_W'(s1_dx1_reg);
            s2_m2_reg   <= tsm_pkg::MUL_W'(s1_dy1_reg) * tsm_pkg::MUL_W'(s1_dx2_reg);
            s2_area_reg <= s1_area_reg;
            s2_side_reg <= s1_side_reg;

            // stage 3
            s3_pp_reg   <= tsm_pkg::PP_W'(s2_gi_reg.p) * tsm_pkg::PP_W'(s2_gj_reg.p);
            s3_qq_reg   <= tsm_pkg::PP_W'(s2_gi_reg.q) * tsm_pkg::PP_W'(s2_gj_reg.q);
            s3_det_reg  <= tsm_pkg::DET_W'(s2_m1_reg) - tsm_pkg::DET_W'(s2_m2_reg);
            s3_area_reg <= s2_area_reg;
            s3_side_reg <= s2_side_reg;

            // stage 4
            s4_num_reg  <= tsm_pkg::NUM_W'(s3_pp_reg) + tsm_pkg::NUM_W'(s3_qq_reg);
            s4_dmag_reg <= s3_det_reg[tsm_pkg::DET_W-1] ? tsm_pkg::DMG_W'(-s3_det_reg)
                                                        : tsm_pkg::DMG_W'(s3_det_reg);
            s4_area_reg <= s3_area_reg;
            s4_side_reg <= s4_side_next;

            // stage 5: square split in 33-bit halves
            s5_nmag_reg <= s4_num_reg[tsm_pkg::NUM_W-1] ? tsm_pkg::NMG_W'(-s4_num_reg)
                                                        : tsm_pkg::NMG_W'(s4_num_reg);
            s5_ll_reg   <= tsm_pkg::MUL_W'(s4_dmag_reg[32:0])
                           * tsm_pkg::MUL_W'(s4_dmag_reg[32:0]);
            s5_lh_reg   <= tsm_pkg::MUL_W'(s4_dmag_reg[32:0])
                           * tsm_pkg::MUL_W'(s4_dmag_reg[65:33]);
            s5_hh_reg   <= tsm_pkg::MUL_W'(s4_dmag_reg[65:33])
                           * tsm_pkg::MUL_W'(s4_dmag_reg[65:33]);
            s5_area_reg <= s4_area_reg;
            s5_side_reg <= s5_side_next;

            // stage 6: cross term counted twice, area split in 24-bit halves
            s6_dsq_reg  <= tsm_pkg::DSQ_W'(s5_ll_reg)
                           + (tsm_pkg::DSQ_W'(s5_lh_reg) << 34)
                           + (tsm_pkg::DSQ_W'(s5_hh_reg) << 66);
            s6_a00_reg  <= tsm_pkg::APP_W'(s5_nmag_reg[33:0])
                           * tsm_pkg::APP_W'(s5_area_reg[23:0]);
            s6_a01_reg  <= tsm_pkg::APP_W'(s5_nmag_reg[33:0])
                           * tsm_pkg::APP_W'(s5_area_reg[47:24]);
            s6_a10_reg  <= tsm_pkg::APP_W'(s5_nmag_reg[67:34])
                           * tsm_pkg::APP_W'(s5_area_reg[23:0]);
            s6_a11_reg  <= tsm_pkg::APP_W'(s5_nmag_reg[67:34])
                           * tsm_pkg::APP_W'(s5_area_reg[47:24]);
            s6_side_reg <= s5_side_reg;

            // stage 7
            s7_prod_reg <= tsm_pkg::PROD_W'(s6_a00_reg)
                           + (tsm_pkg::PROD_W'(s6_a01_reg) << 24)
                           + (tsm_pkg::PROD_W'(s6_a10_reg) << 34)
                           + (tsm_pkg::PROD_W'(s6_a11_reg) << 58);
            s7_dsq_reg  <= s6_dsq_reg;
            s7_side_reg <= s6_side_reg;

            // stage 8: round to nearest as (2N + D) / 2D with N = prod * 2^48
            s8_dvd_reg  <= (tsm_pkg::DVD_W'(s7_prod_reg) << 49)
                           + tsm_pkg::DVD_W'(s7_dsq_reg);
            s8_div2_reg <= {s7_dsq_reg, 1'b0};
            s8_side_reg <= s7_side_reg;

            // stage 9: a top part at or above the divisor means a quotient past 64 bits
            s9_rem_reg  <= s9_rem_next;
            s9_lq_reg   <= s8_dvd_reg[tsm_pkg::VAL_W-1:0];
            s9_div2_reg <= s8_div2_reg;
            s9_side_reg <= s9_side_next;
        end
    end

    tsm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s9_v_reg),
        .in_side   (s9_side_reg),
        .in_rem    (s9_rem_reg),
        .in_lq     (s9_lq_reg),
        .in_div2   (s9_div2_reg),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_quo   (dv_quo)
    );

    // sign, saturation and forced zero
    always_comb
    begin
        if (dv_side.degen || dv_side.zero)
        begin
            value_next = '0;
        end
        else if (dv_side.ovf)
        begin
            value_next = dv_side.neg ? VAL_MIN : VAL_MAX;
        end
        else if (!dv_side.neg)
        begin
            value_next = dv_quo[tsm_pkg::VAL_W-1] ? VAL_MAX : dv_quo;
        end
        else
        begin
            value_next = (dv_quo > VAL_MIN) ? VAL_MIN : (~dv_quo + 64'd1);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            row_reg       <= dv_side.row;
            col_reg       <= dv_side.col;
            value_reg     <= value_next;
            degen_reg     <= dv_side.degen;
            lastt_out_reg <= dv_side.last_tri;
            eom_reg       <= dv_side.end_mesh;
        end
    end

    assign out_valid        = out_valid_reg;
    assign row_index        = row_reg;
    assign col_index        = col_reg;
    assign entry_value      = value_reg;
    assign degenerate       = degen_reg;
    assign last_of_triangle = lastt_out_reg;
    assign end_of_mesh      = eom_reg;

endmodule
